[rtl/erot_pkg.sv]
// Shared widths, register indexes, types and helpers of the Euler point rotator.
package erot_pkg;

    // Coordinate format of points on both channels.
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;

    // Coefficient format: Q1.16 in 18 bits signed; one more bit holds a negated value.
    localparam int COEF_W = 18;
    localparam int MULC_W = COEF_W + 1;

    // Product and sum widths of one rotation.
    localparam int PROD_W = MULC_W + COORD_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SHR_W  = SUM_W - FRAC_BITS;

    // Stream payload width: three coordinates, rounded up to whole bytes.
    localparam int DATA_W = ((3 * COORD_W + 7) / 8) * 8;

    // Configuration port.
    localparam int NUM_REGS  = 6;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = REG_IDX_W + 2;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_COS_Z = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIN_Z = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COS_Y = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SIN_Y = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COS_X = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SIN_X = 3'd5;

    // Reset values of the coefficients (identity rotation).
    localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(65536);
    localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

    // Rounding constant added before the shift.
    localparam logic signed [SUM_W-1:0] ROUND_ADD = SUM_W'(1) << (FRAC_BITS - 1);

    // Saturation limits of one coordinate.
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [MULC_W-1:0]  mulc_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    // All six rotation coefficients as held by the register file.
    typedef struct packed {
        coef_t cos_z;
        coef_t sin_z;
        coef_t cos_y;
        coef_t sin_y;
        coef_t cos_x;
        coef_t sin_x;
    } coef_set_t;

    // Payload that travels alongside the two rotated coordinates.
    typedef struct packed {
        coord_t pass;
        logic   last;
    } side_t;

    // Clamp a shifted sum to the signed coordinate range.
    function automatic coord_t sat_coord(input logic signed [SHR_W-1:0] v);
        logic signed [SHR_W-1:0] hi;
        logic signed [SHR_W-1:0] lo;
        hi = SHR_W'(COORD_MAX);
        lo = SHR_W'(COORD_MIN);
        if (v > hi) begin
            return COORD_MAX;
        end else if (v < lo) begin
            return COORD_MIN;
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

[rtl/erot_cfg_regs.sv]
// Register file for the six rotation coefficients behind a small APB-style port.
module erot_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [erot_pkg::ADDR_W-1:0]   paddr,
    input  logic [erot_pkg::APB_DW-1:0]   pwdata,
    output logic [erot_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output erot_pkg::coef_set_t           coef
);

    erot_pkg::coef_set_t coef_reg;
    erot_pkg::coef_set_t coef_next;
    logic [erot_pkg::REG_IDX_W-1:0] idx;
    logic                           wr_en;
    erot_pkg::coef_t                wval;
    erot_pkg::coef_t                rval;

    assign idx    = paddr[erot_pkg::ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign wval   = pwdata[erot_pkg::COEF_W-1:0];
    assign pready = 1'b1;
    assign coef   = coef_reg;

    // Write decode; indexes past the last register are ignored.
    always_comb begin
        coef_next = coef_reg;
        if (wr_en) begin
            unique case (idx)
                erot_pkg::REG_COS_Z: coef_next.cos_z = wval;
                erot_pkg::REG_SIN_Z: coef_next.sin_z = wval;
                erot_pkg::REG_COS_Y: coef_next.cos_y = wval;
                erot_pkg::REG_SIN_Y: coef_next.sin_y = wval;
                erot_pkg::REG_COS_X: coef_next.cos_x = wval;
                erot_pkg::REG_SIN_X: coef_next.sin_x = wval;
                default: coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.cos_z <= erot_pkg::COEF_ONE;
            coef_reg.sin_z <= erot_pkg::COEF_ZERO;
            coef_reg.cos_y <= erot_pkg::COEF_ONE;
            coef_reg.sin_y <= erot_pkg::COEF_ZERO;
            coef_reg.cos_x <= erot_pkg::COEF_ONE;
            coef_reg.sin_x <= erot_pkg::COEF_ZERO;
        end else begin
            coef_reg <= coef_next;
        end
    end

    // Read mux, sign-extended to the bus width.
    always_comb begin
        unique case (idx)
            erot_pkg::REG_COS_Z: rval = coef_reg.cos_z;
            erot_pkg::REG_SIN_Z: rval = coef_reg.sin_z;
            erot_pkg::REG_COS_Y: rval = coef_reg.cos_y;
            erot_pkg::REG_SIN_Y: rval = coef_reg.sin_y;
            erot_pkg::REG_COS_X: rval = coef_reg.cos_x;
            erot_pkg::REG_SIN_X: rval = coef_reg.sin_x;
            default:             rval = erot_pkg::COEF_ZERO;
        endcase
    end

    assign prdata = erot_pkg::APB_DW'(rval);

endmodule

[rtl/erot_rot_stage.sv]
// One plane rotation p = c*a - s*b, q = s*a + c*b as a two-stage pipeline.
module erot_rot_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  erot_pkg::coef_t      cos_c,
    input  erot_pkg::mulc_t      sin_c,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  erot_pkg::coord_t     in_a,
    input  erot_pkg::coord_t     in_b,
    input  erot_pkg::side_t      in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output erot_pkg::coord_t     out_p,
    output erot_pkg::coord_t     out_q,
    output erot_pkg::side_t      out_side
);

    erot_pkg::mulc_t cos_m;

    // Product stage registers.
    logic            mul_vld_reg;
    erot_pkg::prod_t ca_reg;
    erot_pkg::prod_t sb_reg;
    erot_pkg::prod_t sa_reg;
    erot_pkg::prod_t cb_reg;
    erot_pkg::side_t mul_side_reg;

    // Sum stage registers.
    logic             sum_vld_reg;
    erot_pkg::coord_t p_reg;
    erot_pkg::coord_t q_reg;
    erot_pkg::side_t  sum_side_reg;

    logic mul_rdy;
    logic sum_rdy;

    logic signed [erot_pkg::SUM_W-1:0] p_sum;
    logic signed [erot_pkg::SUM_W-1:0] q_sum;
    logic signed [erot_pkg::SHR_W-1:0] p_shr;
    logic signed [erot_pkg::SHR_W-1:0] q_shr;
    erot_pkg::coord_t p_next;
    erot_pkg::coord_t q_next;

    assign cos_m = erot_pkg::MULC_W'(cos_c);

    // A stage takes new data when it is empty or its content moves on.
    assign sum_rdy  = !sum_vld_reg || out_ready;
    assign mul_rdy  = !mul_vld_reg || sum_rdy;
    assign in_ready = mul_rdy;

    // Stage 1: four products.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
        end else if (mul_rdy) begin
            mul_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_rdy && in_valid) begin
            ca_reg       <= erot_pkg::PROD_W'(cos_m) * erot_pkg::PROD_W'(in_a);
            sb_reg       <= erot_pkg::PROD_W'(sin_c) * erot_pkg::PROD_W'(in_b);
            sa_reg       <= erot_pkg::PROD_W'(sin_c) * erot_pkg::PROD_W'(in_a);
            cb_reg       <= erot_pkg::PROD_W'(cos_m) * erot_pkg::PROD_W'(in_b);
            mul_side_reg <= in_side;
        end
    end

    // Stage 2: sum, round half up, drop the fraction and saturate.
    always_comb begin
        p_sum  = erot_pkg::SUM_W'(ca_reg) - erot_pkg::SUM_W'(sb_reg) + erot_pkg::ROUND_ADD;
        q_sum  = erot_pkg::SUM_W'(sa_reg) + erot_pkg::SUM_W'(cb_reg) + erot_pkg::ROUND_ADD;
        p_shr  = p_sum[erot_pkg::SUM_W-1:erot_pkg::FRAC_BITS];
        q_shr  = q_sum[erot_pkg::SUM_W-1:erot_pkg::FRAC_BITS];
        p_next = erot_pkg::sat_coord(p_shr);
        q_next = erot_pkg::sat_coord(q_shr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_vld_reg <= 1'b0;
        end else if (sum_rdy) begin
            sum_vld_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_rdy && mul_vld_reg) begin
            p_reg        <= p_next;
            q_reg        <= q_next;
            sum_side_reg <= mul_side_reg;
        end
    end

    assign out_valid = sum_vld_reg;
    assign out_p     = p_reg;
    assign out_q     = q_reg;
    assign out_side  = sum_side_reg;

endmodule

[rtl/euler_point_rotator_top.sv]
// Top level of the Euler point rotator: register file and three rotation pipelines.

// Rotates one signed fixed-point 3D point per transaction by extrinsic z, then y,
// then x rotations whose cosines and sines (Q1.16, 18 bits signed) sit in APB
// registers 0..5 at byte addresses 0, 4, ..., 20: cos_z, sin_z, cos_y, sin_y, cos_x,
// sin_x; reset gives the identity. Each rotation rounds half up, drops 16 fraction
// bits and saturates to 32 bits before feeding the next. The datapath is six
// register stages (a product stage and a sum/saturate stage per rotation), and one
// point can enter every cycle while the output is taken. Each stage has its own
// valid bit and stalls only when the stage after it is full, so bubbles are squeezed
// out under backpressure.
// Write coefficients only while no point is in flight.
module euler_point_rotator_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [erot_pkg::ADDR_W-1:0]   paddr,
    input  logic [erot_pkg::APB_DW-1:0]   pwdata,
    output logic [erot_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    // Input points
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [erot_pkg::DATA_W-1:0]   s_tdata,  // pos_x, pos_y, pos_z from bit 0 up
    input  logic                          s_tlast,
    // Rotated points
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [erot_pkg::DATA_W-1:0]   m_tdata,  // rot_x, rot_y, rot_z from bit 0 up
    output logic                          m_tlast
);

    localparam int CW = erot_pkg::COORD_W;

    erot_pkg::coef_set_t coef;
    erot_pkg::mulc_t     sin_z_m;
    erot_pkg::mulc_t     sin_y_neg;
    erot_pkg::mulc_t     sin_x_m;

    erot_pkg::side_t  in_side;
    logic             zr_valid;
    logic             zr_ready;
    erot_pkg::coord_t x1;
    erot_pkg::coord_t y1;
    erot_pkg::side_t  zr_side;
    erot_pkg::side_t  zr_side_fwd;
    logic             yr_valid;
    logic             yr_ready;
    erot_pkg::coord_t x2;
    erot_pkg::coord_t z1;
    erot_pkg::side_t  yr_side;
    erot_pkg::side_t  yr_side_fwd;
    erot_pkg::coord_t y2;
    erot_pkg::coord_t z2;
    erot_pkg::side_t  xr_side;

    // Coefficient registers.
    erot_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    // The y rotation runs with the sine negated; one extra bit keeps the most negative code.
    assign sin_z_m   = erot_pkg::MULC_W'(coef.sin_z);
    assign sin_y_neg = -erot_pkg::MULC_W'(coef.sin_y);
    assign sin_x_m   = erot_pkg::MULC_W'(coef.sin_x);

    assign in_side.pass = s_tdata[3*CW-1:2*CW];
    assign in_side.last = s_tlast;

    // Rotation about z on (x, y); z rides along.
    erot_rot_stage u_rot_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cos_c     (coef.cos_z),
        .sin_c     (sin_z_m),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_a      (s_tdata[CW-1:0]),
        .in_b      (s_tdata[2*CW-1:CW]),
        .in_side   (in_side),
        .out_valid (zr_valid),
        .out_ready (zr_ready),
        .out_p     (x1),
        .out_q     (y1),
        .out_side  (zr_side)
    );

    assign zr_side_fwd.pass = y1;
    assign zr_side_fwd.last = zr_side.last;

    // Rotation about y on (x1, z); y1 rides along.
    erot_rot_stage u_rot_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cos_c     (coef.cos_y),
        .sin_c     (sin_y_neg),
        .in_valid  (zr_valid),
        .in_ready  (zr_ready),
        .in_a      (x1),
        .in_b      (zr_side.pass),
        .in_side   (zr_side_fwd),
        .out_valid (yr_valid),
        .out_ready (yr_ready),
        .out_p     (x2),
        .out_q     (z1),
        .out_side  (yr_side)
    );

    assign yr_side_fwd.pass = x2;
    assign yr_side_fwd.last = yr_side.last;

    // Rotation about x on (y1, z1); x2 rides along.
    erot_rot_stage u_rot_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cos_c     (coef.cos_x),
        .sin_c     (sin_x_m),
        .in_valid  (yr_valid),
        .in_ready  (yr_ready),
        .in_a      (yr_side.pass),
        .in_b      (z1),
        .in_side   (yr_side_fwd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_p     (y2),
        .out_q     (z2),
        .out_side  (xr_side)
    );

    // Output packing.
    assign m_tdata = erot_pkg::DATA_W'({z2, y2, xr_side.pass});
    assign m_tlast = xr_side.last;

`ifndef SYNTH
    // Nothing comes out in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // With the output side taking results, the whole pipeline moves and input is open.
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

    // A write to sin_y shows in the register file on the next cycle.
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && paddr[erot_pkg::ADDR_W-1:2] == erot_pkg::REG_SIN_Y)
        |=> coef.sin_y == $past(pwdata[erot_pkg::COEF_W-1:0]))
        else $error("sin_y register write lost");

    // A stalled inter-rotation hand-off keeps its valid.
    a_mid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (yr_valid && !yr_ready) |=> yr_valid)
        else $error("mid-pipeline item dropped under stall");
`endif

endmodule
